/* rtl/tlc_pkg.sv */
package tlc_pkg;

    // Address layout: byte offset in the lowest bits, tag in the upper half.
    localparam int OFFSET_W = 2;
    localparam int TAG_LSB  = 16;
    localparam int TAG_W    = 16;
    localparam int CNT_W    = 32;

    // One set as it is stored in the set memory.
    typedef struct packed {
        logic [TAG_W-1:0] tag1;
        logic [TAG_W-1:0] tag0;
        logic             valid1;
        logic             valid0;
        logic             victim_is_way1;
    } t_set_entry;

    // Outcome of one lookup, passed from the update logic to the top level.
    typedef struct packed {
        logic hit;
        logic way;
    } t_lookup;

endpackage

/* rtl/tlc_set_ram.sv */
module tlc_set_ram
    import tlc_pkg::*;
#(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  t_set_entry           i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_W-1:0]    i_raddr,
    output t_set_entry           o_rdata
);

    t_set_entry r_mem [DEPTH];
    t_set_entry r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, enabled so the data holds while the lookup waits.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tlc_update.sv */
module tlc_update
    import tlc_pkg::*;
(
    input  t_set_entry       i_entry,
    input  logic [TAG_W-1:0] i_tag,
    output t_set_entry       o_entry,
    output t_lookup          o_lookup
);

    logic w_hit0;
    logic w_hit1;

    // Way 0 is compared first, so it wins if both ways match.
    assign w_hit0 = i_entry.valid0 && (i_entry.tag0 == i_tag);
    assign w_hit1 = i_entry.valid1 && (i_entry.tag1 == i_tag);

    // On a hit the other way becomes the victim; on a miss the victim is refilled.
    always_comb begin
        o_entry = i_entry;
        if (w_hit0) begin
            o_lookup.hit           = 1'b1;
            o_lookup.way           = 1'b0;
            o_entry.victim_is_way1 = 1'b1;
        end else if (w_hit1) begin
            o_lookup.hit           = 1'b1;
            o_lookup.way           = 1'b1;
            o_entry.victim_is_way1 = 1'b0;
        end else if (i_entry.victim_is_way1) begin
            o_lookup.hit           = 1'b0;
            o_lookup.way           = 1'b1;
            o_entry.tag1           = i_tag;
            o_entry.valid1         = 1'b1;
            o_entry.victim_is_way1 = 1'b0;
        end else begin
            o_lookup.hit           = 1'b0;
            o_lookup.way           = 1'b0;
            o_entry.tag0           = i_tag;
            o_entry.valid0         = 1'b1;
            o_entry.victim_is_way1 = 1'b1;
        end
    end

endmodule

/* rtl/two_way_lru_cache_tag_lookup.sv */
// Two-way set-associative cache tag lookup with one LRU victim bit per set.
// Each input word is a byte address: bits 31..16 are the tag and the bits above
// the two-bit byte offset select the set. Each output word reports hit or miss,
// the way that hit or was filled, and the saturating hit and miss totals that
// include this access. An access is a registered read of the set memory followed
// by a step that compares, updates the set and writes it back; a new address is
// taken only once the previous lookup has completed. The output register lets the
// next lookup start while a result still waits. After reset the block clears all
// SETS sets of the set memory (16384 by default), one set per cycle; tready stays
// low during that pass.
module two_way_lru_cache_tag_lookup
    import tlc_pkg::*;
#(
    parameter int SETS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] address
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata    // [0] hit, [1] way, [33:2] hit_total,
                                     // [65:34] miss_total, [71:66] zero
);

    localparam int SET_W = $clog2(SETS);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [SET_W-1:0]   r_clr_idx;
    logic [SET_W-1:0]   r_set;
    logic [TAG_W-1:0]   r_tag;
    logic [CNT_W-1:0]   r_hit_cnt, n_hit_cnt;
    logic [CNT_W-1:0]   r_miss_cnt, n_miss_cnt;
    logic               r_m_valid;
    t_lookup            r_m_result;

    logic               w_accept;
    logic               w_adv;
    logic               w_we;
    logic [SET_W-1:0]   w_waddr;
    t_set_entry         w_wdata;
    t_set_entry         w_rdata;
    t_set_entry         w_new_entry;
    t_lookup            w_lookup;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_adv      = (r_state == ST_LOOKUP) && (!r_m_valid || i_m_tready);

    // Set memory: the clearing pass writes empty sets, a lookup writes back its set.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_set;
        w_wdata = w_new_entry;
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = '0;
        end else if (w_adv) begin
            w_we = 1'b1;
        end
    end

    tlc_set_ram #(
        .DEPTH  (SETS),
        .ADDR_W (SET_W)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (i_s_tdata[OFFSET_W +: SET_W]),
        .o_rdata (w_rdata)
    );

    tlc_update u_update (
        .i_entry  (w_rdata),
        .i_tag    (r_tag),
        .o_entry  (w_new_entry),
        .o_lookup (w_lookup)
    );

    // Sequencer: clear pass, wait for an address, then finish the lookup.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == SET_W'(SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (w_adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Saturating counters, advanced when a lookup completes.
    always_comb begin
        n_hit_cnt  = r_hit_cnt;
        n_miss_cnt = r_miss_cnt;
        if (w_adv) begin
            if (w_lookup.hit) begin
                if (r_hit_cnt != '1) begin
                    n_hit_cnt = r_hit_cnt + CNT_W'(1);
                end
            end else if (r_miss_cnt != '1) begin
                n_miss_cnt = r_miss_cnt + CNT_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_idx  <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_hit_cnt  <= n_hit_cnt;
            r_miss_cnt <= n_miss_cnt;
            if (r_state == ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (w_adv) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the captured address and the result word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set <= i_s_tdata[OFFSET_W +: SET_W];
            r_tag <= i_s_tdata[TAG_LSB +: TAG_W];
        end
        if (w_adv) begin
            r_m_result <= w_lookup;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b0, r_miss_cnt, r_hit_cnt, r_m_result.way, r_m_result.hit};

    // A taken address always starts a lookup in the next cycle.
    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LOOKUP))
        else $error("accepted address did not start a lookup");

    // A completed lookup always leaves a valid result word.
    a_adv_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_m_tvalid)
        else $error("completed lookup did not produce a result word");

    // The set memory is never written while the block waits for an address.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_we)
        else $error("set memory written while idle");

    // At most one counter moves per completed lookup; this checks that none moves otherwise.
    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_hit_cnt) && $stable(r_miss_cnt)))
        else $error("counter changed without a completed lookup");

endmodule

/* tb/two_way_lru_cache_tag_lookup_checker.sv */
`timescale 1ns / 100ps

// Watches both streams of the tag lookup and keeps its own copy of the tag
// arrays, valid bits, victim bits and totals. Every accepted address word is
// turned into the expected result word. Every accepted result word is compared
// with the oldest expected one.
module two_way_lru_cache_tag_lookup_checker
    import tlc_pkg::*;
#(
    parameter int SETS = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] address
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,   // [0] hit, [1] way, [33:2] hit_total,
                                     // [65:34] miss_total, [71:66] zero
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SET_W = $clog2(SETS);

    // Result word as it leaves the block, hit in bit 0.
    typedef struct packed {
        logic [5:0]       pad;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] hit_total;
        logic             way;
        logic             hit;
    } t_result_word;

    logic [TAG_W-1:0] tag_way0 [SETS];
    logic [TAG_W-1:0] tag_way1 [SETS];
    bit               valid_way0 [SETS];
    bit               valid_way1 [SETS];
    bit               victim_way1 [SETS];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    t_result_word     results_due [$];
    int               fail_count;

    // Look up one address in the predicted cache, update the set and the totals.
    function automatic t_result_word lookup_address(input logic [31:0] address);
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set_idx;
        t_result_word     res;
        tag     = address[TAG_LSB +: TAG_W];
        set_idx = address[OFFSET_W +: SET_W];
        res     = '0;
        if (valid_way0[set_idx] && tag_way0[set_idx] == tag) begin
            res.hit              = 1'b1;
            res.way              = 1'b0;
            victim_way1[set_idx] = 1'b1;
        end else if (valid_way1[set_idx] && tag_way1[set_idx] == tag) begin
            res.hit              = 1'b1;
            res.way              = 1'b1;
            victim_way1[set_idx] = 1'b0;
        end else if (victim_way1[set_idx]) begin
            // Miss with way 1 as the victim: fill it, way 0 goes next.
            res.way              = 1'b1;
            tag_way1[set_idx]    = tag;
            valid_way1[set_idx]  = 1'b1;
            victim_way1[set_idx] = 1'b0;
        end else begin
            res.way              = 1'b0;
            tag_way0[set_idx]    = tag;
            valid_way0[set_idx]  = 1'b1;
            victim_way1[set_idx] = 1'b1;
        end
        // Totals stop at their maximum.
        if (res.hit) begin
            if (hit_count != '1) hit_count = hit_count + CNT_W'(1);
        end else begin
            if (miss_count != '1) miss_count = miss_count + CNT_W'(1);
        end
        res.hit_total  = hit_count;
        res.miss_total = miss_count;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] expected,
                               input logic [63:0] actual);
        if (expected !== actual) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, expected, actual);
        end
    endtask

    // Predict on every accepted address word, compare on every result word.
    always @(posedge i_clk) begin
        t_result_word due;
        t_result_word seen;
        if (!i_rst_n) begin
            for (int i = 0; i < SETS; i++) begin
                valid_way0[i]  = 1'b0;
                valid_way1[i]  = 1'b0;
                victim_way1[i] = 1'b0;
            end
            hit_count  = '0;
            miss_count = '0;
            results_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                results_due.push_back(lookup_address(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata;
                if (results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected result word, expected none, actual 0x%0h",
                             $time, i_m_tdata);
                end else begin
                    due = results_due.pop_front();
                    check_field("hit", 64'(due.hit), 64'(seen.hit));
                    check_field("way", 64'(due.way), 64'(seen.way));
                    check_field("hit_total", 64'(due.hit_total), 64'(seen.hit_total));
                    check_field("miss_total", 64'(due.miss_total), 64'(seen.miss_total));
                    check_field("padding", 64'(due.pad), 64'(seen.pad));
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= results_due.size();
    end

endmodule

/* tb/two_way_lru_cache_tag_lookup_tb.sv */
`timescale 1ns / 100ps

// Drives address words into the tag lookup and drains its result words with
// random gaps and stalls. The checker beside the block does all prediction.
module two_way_lru_cache_tag_lookup_tb;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          gaps_on  = 1'b0;
    bit          stall_on = 1'b0;

    two_way_lru_cache_tag_lookup u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    two_way_lru_cache_tag_lookup_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The run ends here if the block stops moving words.
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: when stalls are on, stall for a random number of cycles before each word.
    initial begin
        int stall;
        forever begin
            stall = stall_on ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Offer one address word after an optional gap and hold it until taken.
    task automatic send_address(input logic [31:0] address);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= address;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // Stop sending and wait until every expected result word has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        logic [31:0] directed_addrs [23];
        logic [13:0] set_pool [6];
        logic [15:0] tag_pool [4];
        logic [1:0]  mode;
        logic [31:0] address;

        directed_addrs = '{
            32'h0000_0000, 32'h0000_0003, 32'h0001_0000, 32'h0000_0000,
            32'h0002_0000, 32'h0001_0002, 32'h0002_0001, 32'h0001_0001,
            32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0000_FFFC, 32'hFFFF_FFFD,
            32'h1234_FFFF, 32'h0000_FFFE, 32'hFFFF_0000, 32'h5555_AAAA,
            32'hAAAA_5555, 32'h5555_AAA9, 32'hAAAA_5556, 32'h8000_0004,
            32'h0001_8000, 32'h8000_0004, 32'h0001_8000
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Back-to-back directed words first: hits in both ways, fills of
        // both ways, eviction by the victim bit, ignored byte offset, the
        // lowest and highest set and tag, and the same set at full rate.
        foreach (directed_addrs[i]) send_address(directed_addrs[i]);
        // The same words again with gaps and stalls.
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        foreach (directed_addrs[i]) send_address(directed_addrs[i]);

        // A few sets and tags shared by most random words so that hits,
        // evictions and reuse are frequent.
        set_pool[0] = '0;
        set_pool[1] = '1;
        for (int i = 2; i < 6; i++) set_pool[i] = 14'($urandom_range(0, 16383));
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = 16'($urandom_range(0, 65535));
        tag_pool[3] = 16'($urandom_range(0, 65535));

        for (int n = 0; n < 1800; n++) begin
            if (n % 200 == 0) begin
                mode     = (n == 0) ? 2'd3 : (n == 200) ? 2'd0 : 2'($urandom_range(0, 3));
                gaps_on  = mode[0];
                stall_on = mode[1];
            end
            if (n == 900) drain_results();
            if ($urandom_range(0, 99) < 85) begin
                address = {tag_pool[$urandom_range(0, 3)], set_pool[$urandom_range(0, 5)],
                           2'($urandom_range(0, 3))};
            end else begin
                address = $urandom;
            end
            send_address(address);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
